// ===== rtl/core/mwlfo_pkg.sv =====
// Shared types and constants for the multi-wave LFO.
`timescale 1ns / 1ps
`default_nettype none

package mwlfo_pkg;

    // Waveform select codes
    localparam logic [2:0] WAVE_SAW_UP   = 3'd0;
    localparam logic [2:0] WAVE_SAW_DOWN = 3'd1;
    localparam logic [2:0] WAVE_SQUARE   = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_SKEWED   = 3'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W      = 2;
    localparam int          CFG_DATA_W     = 24;
    localparam logic [1:0]  CFG_PHASE_INC  = 2'd0;
    localparam logic [1:0]  CFG_WAVEFORM   = 2'd1;
    localparam logic [1:0]  CFG_SKEW_POINT = 2'd2;

    // Skew point is Q0.16; the divisor needs one more bit to hold 1.0
    localparam int          SKEW_W         = 16;
    localparam int          DIV_W          = SKEW_W + 1;
    localparam logic [16:0] SKEW_ONE       = 17'h10000;

    // Reset values
    localparam logic [2:0]  WAVEFORM_RST   = WAVE_TRIANGLE;
    localparam logic [15:0] SKEW_POINT_RST = 16'h8000;

    // Controller to datapath commands
    typedef struct packed {
        logic step;       // take the input transfer, advance the phase
        logic div_start;  // load the divider for the skewed shape
        logic load_out;   // shaped sample goes to the output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic skew_mode;  // skewed shape selected, needs the divider
        logic div_busy;   // divider still iterating
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/mwlfo_div.sv =====
// Restoring divider, one quotient bit per cycle, for the skewed wave.
`timescale 1ns / 1ps
`default_nettype none

module mwlfo_div #(
    parameter int PHASE_BITS = 24
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [PHASE_BITS+mwlfo_pkg::SKEW_W-1:0] numer,
    input  wire logic [mwlfo_pkg::DIV_W-1:0]           denom,
    output logic                                       busy,
    output logic [PHASE_BITS-1:0]                      quot
);

    localparam int CNT_W = $clog2(PHASE_BITS + 1);
    localparam int DW    = mwlfo_pkg::DIV_W;

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         den_reg, den_next;
    logic [PHASE_BITS-1:0] quo_reg, quo_next;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        fits;

    // Quotient is known to fit PHASE_BITS, so the top bits of the
    // numerator start out below the divisor.
    assign trial = {rem_reg, quo_reg[PHASE_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(PHASE_BITS);
            rem_next = {1'b0, numer[PHASE_BITS+mwlfo_pkg::SKEW_W-1:PHASE_BITS]};
            den_next = denom;
            quo_next = numer[PHASE_BITS-1:0];
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {quo_reg[PHASE_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy = cnt_reg != '0;
    assign quot = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mwlfo_dp.sv =====
// LFO datapath: phase accumulator, skew divider setup and waveshaper.
`timescale 1ns / 1ps
`default_nettype none

module mwlfo_dp #(
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mwlfo_pkg::ctrl_cmd_t        cmd,
    input  wire logic                        restart,
    input  wire logic [PHASE_BITS-1:0]       phase_inc,
    input  wire logic [2:0]                  waveform,
    input  wire logic [mwlfo_pkg::SKEW_W-1:0] skew_point,
    output mwlfo_pkg::dp_status_t            status,
    output logic [SAMPLE_BITS-1:0]           wave_sample,
    output logic [PHASE_BITS-1:0]            phase_now
);

    localparam int KW = mwlfo_pkg::SKEW_W;
    localparam int NW = PHASE_BITS + KW;
    localparam int VW = SAMPLE_BITS + 2;

    localparam logic signed [VW-1:0] HALF_S = VW'(1) << (SAMPLE_BITS - 1);
    localparam logic signed [VW-1:0] MAX_V  = HALF_S - VW'(1);
    localparam logic signed [VW-1:0] MIN_V  = -HALF_S;
    localparam logic [PHASE_BITS-1:0] HALF_P = PHASE_BITS'(1) << (PHASE_BITS - 1);

    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;

    always_comb
    begin
        phase_acc_next = phase_acc_reg;
        if (cmd.step)
        begin
            phase_acc_next = (restart ? '0 : phase_acc_reg) + phase_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
        end
        else
        begin
            phase_acc_reg <= phase_acc_next;
        end
    end

    // Skewed wave: pick the segment and set up the division
    logic [NW-1:0]                  p16;
    logic [NW-1:0]                  k_ph;
    logic                           rising;
    logic [NW-1:0]                  numer;
    logic [mwlfo_pkg::DIV_W-1:0]    denom;
    logic [PHASE_BITS-1:0]          quot;
    logic                           div_busy;

    assign p16    = {phase_acc_reg, {KW{1'b0}}};
    assign k_ph   = {skew_point, {PHASE_BITS{1'b0}}};
    assign rising = p16 < k_ph;
    assign numer  = rising ? p16 : (p16 - k_ph);
    assign denom  = rising ? {1'b0, skew_point} : (mwlfo_pkg::SKEW_ONE - {1'b0, skew_point});

    mwlfo_div #(
        .PHASE_BITS (PHASE_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (numer),
        .denom (denom),
        .busy  (div_busy),
        .quot  (quot)
    );

    // Scale a phase fraction to the sample range: frac * 2S / 2^PHASE_BITS
    logic [PHASE_BITS+SAMPLE_BITS-1:0] prod_p;
    logic [PHASE_BITS+SAMPLE_BITS-1:0] prod_q;
    logic [PHASE_BITS+SAMPLE_BITS:0]   prod_t;
    logic [SAMPLE_BITS-1:0]            u_phase;
    logic [SAMPLE_BITS-1:0]            u_quot;
    logic [SAMPLE_BITS:0]              u_tri;
    logic [PHASE_BITS-1:0]             tri_dist;

    assign tri_dist = (phase_acc_reg >= HALF_P) ? (phase_acc_reg - HALF_P)
                                                : (HALF_P - phase_acc_reg);
    assign prod_p   = {phase_acc_reg, {SAMPLE_BITS{1'b0}}};
    assign prod_q   = {quot, {SAMPLE_BITS{1'b0}}};
    assign prod_t   = {tri_dist, {(SAMPLE_BITS + 1){1'b0}}};
    assign u_phase  = prod_p[PHASE_BITS+SAMPLE_BITS-1:PHASE_BITS];
    assign u_quot   = prod_q[PHASE_BITS+SAMPLE_BITS-1:PHASE_BITS];
    assign u_tri    = prod_t[PHASE_BITS+SAMPLE_BITS:PHASE_BITS];

    logic signed [VW-1:0] shaped;

    always_comb
    begin
        case (waveform)
            mwlfo_pkg::WAVE_SAW_UP:
                shaped = $signed({2'b00, u_phase}) - HALF_S;
            mwlfo_pkg::WAVE_SAW_DOWN:
                shaped = HALF_S - $signed({2'b00, u_phase});
            mwlfo_pkg::WAVE_SQUARE:
                shaped = phase_acc_reg[PHASE_BITS-1] ? MAX_V : MIN_V;
            mwlfo_pkg::WAVE_SKEWED:
                shaped = rising ? ($signed({2'b00, u_quot}) - HALF_S)
                                : (HALF_S - $signed({2'b00, u_quot}));
            default:
                shaped = $signed({1'b0, u_tri}) - HALF_S;
        endcase
    end

    logic signed [VW-1:0] clamped;

    always_comb
    begin
        if (shaped > MAX_V)
        begin
            clamped = MAX_V;
        end
        else if (shaped < MIN_V)
        begin
            clamped = MIN_V;
        end
        else
        begin
            clamped = shaped;
        end
    end

    assign wave_sample      = clamped[SAMPLE_BITS-1:0];
    assign phase_now        = phase_acc_reg;
    assign status.skew_mode = waveform == mwlfo_pkg::WAVE_SKEWED;
    assign status.div_busy  = div_busy;

endmodule

`default_nettype wire

// ===== rtl/core/mwlfo_ctrl.sv =====
// LFO sequencer: input acceptance, divider run and output hand-off.
`timescale 1ns / 1ps
`default_nettype none

module mwlfo_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic                   out_free,
    input  wire mwlfo_pkg::dp_status_t  status,
    output mwlfo_pkg::ctrl_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.step      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step   = 1'b1;
                    state_next = status.skew_mode ? ST_SETUP : ST_OUT;
                end
            end
            ST_SETUP:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multi_wave_lfo.sv =====
// Multi-wave LFO top level: config registers, output register, core wiring.
//
// Phase-accumulator LFO. Each input transfer is one tick: the phase clears if
// restart is set, then advances by phase_increment modulo one, and the new
// phase is shaped into a saturated signed Q1.(SAMPLE_BITS-1) sample (saw up,
// saw down, square, triangle, or skewed saw-triangle). One result transfer
// follows each input transfer. The input is taken in the idle state; for the
// plain shapes the result is registered from the output state as soon as the
// output register is free. The skewed shape first starts a restoring divider
// in the setup state and waits in the divide state while it yields one
// quotient bit per cycle before it reaches the output state. The next input
// is accepted as soon as the previous result sits in the output register,
// even while it waits for m_tready, so a new tick can start meanwhile.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no tick is in flight; an index of 3 is ignored.
// Waveform codes 5 to 7 give the triangle.
`timescale 1ns / 1ps
`default_nettype none

module multi_wave_lfo #(
    parameter int PHASE_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,

    // Input stream, one tick per transfer
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [7:0]                            s_tdata,   // [0] restart

    // Result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // m_tdata, lowest bit up: wave_sample, phase_now, zero pad to bytes
    output logic [((SAMPLE_BITS+PHASE_BITS+7)/8)*8-1:0] m_tdata,

    // Configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mwlfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mwlfo_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int OUT_W = ((SAMPLE_BITS + PHASE_BITS + 7) / 8) * 8;
    localparam int KW    = mwlfo_pkg::SKEW_W;

    // ---------------- configuration registers ----------------
    logic [PHASE_BITS-1:0] phase_inc_reg, phase_inc_next;
    logic [2:0]            waveform_reg, waveform_next;
    logic [KW-1:0]         skew_reg, skew_next;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    always_comb
    begin
        phase_inc_next = phase_inc_reg;
        waveform_next  = waveform_reg;
        skew_next      = skew_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                mwlfo_pkg::CFG_PHASE_INC:  phase_inc_next = PHASE_BITS'(cfg_data);
                mwlfo_pkg::CFG_WAVEFORM:   waveform_next  = cfg_data[2:0];
                mwlfo_pkg::CFG_SKEW_POINT: skew_next      = cfg_data[KW-1:0];
                default:                   ;  // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= '0;
            waveform_reg  <= mwlfo_pkg::WAVEFORM_RST;
            skew_reg      <= mwlfo_pkg::SKEW_POINT_RST;
        end
        else
        begin
            phase_inc_reg <= phase_inc_next;
            waveform_reg  <= waveform_next;
            skew_reg      <= skew_next;
        end
    end

    // ---------------- controller and datapath ----------------
    mwlfo_pkg::ctrl_cmd_t  cmd;
    mwlfo_pkg::dp_status_t status;
    logic                  out_free;
    logic [SAMPLE_BITS-1:0] wave_sample;
    logic [PHASE_BITS-1:0]  phase_now;

    mwlfo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    mwlfo_dp #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .restart     (s_tdata[0]),
        .phase_inc   (phase_inc_reg),
        .waveform    (waveform_reg),
        .skew_point  (skew_reg),
        .status      (status),
        .wave_sample (wave_sample),
        .phase_now   (phase_now)
    );

    // ---------------- output register ----------------
    // Holds one finished result so a new tick can start while it waits.
    logic             out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_W'({phase_now, wave_sample});
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the multi-wave LFO: directed and randomized tick streams.
`timescale 1ns / 1ps

module tb;

    import mwlfo_pkg::*;

    localparam int PH_W        = 24;
    localparam int SMP_W       = 16;
    localparam int OUT_W       = ((SMP_W + PH_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;      // wait after the last result before register writes
    localparam int RUN_PHASES  = 12;
    localparam int RUN_TICKS   = 34;

    // Index 3 is outside the register map; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam longint          HALF_S  = 64'sd32768;
    localparam longint unsigned TWO_S   = 64'd65536;
    localparam longint unsigned PH_HALF = 64'd1 << (PH_W - 1);

    typedef struct {
        logic signed [SMP_W-1:0] sample;
        logic [PH_W-1:0]         phase;
    } lfo_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;     // [0] restart
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;          // [15:0] wave_sample, [39:16] phase_now
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block's registers and phase, updated on each accepted transfer
    logic [PH_W-1:0]   inc_reg   = '0;
    logic [2:0]        wave_reg  = WAVEFORM_RST;
    logic [SKEW_W-1:0] skew_reg  = SKEW_POINT_RST;
    logic [PH_W-1:0]   lfo_phase = '0;

    lfo_result_t pending_results[$];

    bit idle_on = 1'b0;
    int error_count = 0;
    int cycle_count = 0;
    int tick_count = 0;
    int restart_count = 0;
    int setting_count = 0;
    int result_count = 0;
    int wave_hits[8];
    int sink_left = 0;

    multi_wave_lfo DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver backpressure: with idle_on, random bursts of stall or ready; else always ready
    always @(posedge clk)
    begin
        if (!idle_on)
            m_tready <= 1'b1;
        else if (sink_left == 0)
        begin
            sink_left = $urandom_range(1, 15);
            m_tready <= ($urandom_range(0, 1) == 0);
        end
        else
            sink_left--;
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Shape a phase into a saturated Q1.15 sample under the current register mirror.
    function automatic logic signed [SMP_W-1:0] shape_phase(logic [PH_W-1:0] ph);
        longint unsigned p;
        longint unsigned k;
        longint unsigned p16;
        longint unsigned k_ph;
        longint unsigned tri_gap;
        longint unsigned quo;
        longint          v;
        p = ph;
        k = skew_reg;
        case (wave_reg)
            WAVE_SAW_UP:   v = longint'((p * TWO_S) >> PH_W) - HALF_S;
            WAVE_SAW_DOWN: v = HALF_S - longint'((p * TWO_S) >> PH_W);
            WAVE_SQUARE:   v = (p >= PH_HALF) ? (HALF_S - 1) : -HALF_S;
            WAVE_SKEWED:
            begin
                p16  = p << 16;
                k_ph = k << PH_W;
                if (p16 < k_ph)
                begin
                    // rising part, k is nonzero here
                    quo = p16 / k;
                    v = longint'((quo * TWO_S) >> PH_W) - HALF_S;
                end
                else
                begin
                    // falling part; k = 0 makes the whole cycle fall
                    quo = (p16 - k_ph) / (64'd65536 - k);
                    v = HALF_S - longint'((quo * TWO_S) >> PH_W);
                end
            end
            default:
            begin
                // triangle, also for the spare codes 5..7
                tri_gap = (p >= PH_HALF) ? (p - PH_HALF) : (PH_HALF - p);
                v = longint'((tri_gap * TWO_S * 2) >> PH_W) - HALF_S;
            end
        endcase
        if (v > HALF_S - 1)
            v = HALF_S - 1;
        if (v < -HALF_S)
            v = -HALF_S;
        return v[SMP_W-1:0];
    endfunction

    // One tick transfer; s_tvalid stays high into the next call unless a gap is drawn
    task automatic send_tick(bit restart);
        lfo_result_t want;
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        if (restart)
            lfo_phase = '0;
        lfo_phase   = lfo_phase + inc_reg;
        want.phase  = lfo_phase;
        want.sample = shape_phase(lfo_phase);
        pending_results.push_back(want);
        tick_count++;
        restart_count += restart;
        wave_hits[wave_reg]++;
    endtask

    // Stop input and let the block go fully idle before touching registers
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_PHASE_INC:  inc_reg  = data[PH_W-1:0];
            CFG_WAVEFORM:   wave_reg = data[2:0];
            CFG_SKEW_POINT: skew_reg = data[SKEW_W-1:0];
            default:        ;
        endcase
    endtask

    task automatic apply_settings(logic [23:0] inc, logic [23:0] wave_word,
                                  logic [15:0] skew, bit junk_write);
        drain();
        write_reg(CFG_PHASE_INC, inc);
        write_reg(CFG_WAVEFORM, wave_word);
        if (junk_write)
            write_reg(CFG_UNUSED_IDX, 24'($urandom()));
        write_reg(CFG_SKEW_POINT, {8'h00, skew});
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Result checker: every accepted result against the oldest prediction
    always @(posedge clk)
    begin : check_results
        lfo_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_count++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result %h", m_tdata));
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[SMP_W-1:0] !== want.sample)
                    report_mismatch($sformatf("result %0d wave_sample %0d, want %0d",
                        result_count, $signed(m_tdata[SMP_W-1:0]), want.sample));
                if (m_tdata[SMP_W+PH_W-1:SMP_W] !== want.phase)
                    report_mismatch($sformatf("result %0d phase_now %h, want %h",
                        result_count, m_tdata[SMP_W+PH_W-1:SMP_W], want.phase));
            end
        end
    end

    // Registers at their reset values: zero increment, triangle at phase zero
    task automatic test_reset_state;
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Half-cycle steps hit phase zero and the half point; full-scale clips
    task automatic test_basic_shapes;
        apply_settings(24'h800000, WAVE_SAW_UP, 16'h8000, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        apply_settings(24'h800000, WAVE_SAW_DOWN, 16'h8000, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        apply_settings(24'h800000, WAVE_SQUARE, 16'h8000, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        // largest step: phase just under one, then wrapping
        apply_settings(24'hFFFFFF, WAVE_SAW_UP, 16'h8000, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        apply_settings(24'h400000, WAVE_TRIANGLE, 16'h8000, 1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
    endtask

    // Codes 5..7 fall back to the triangle; upper data bits must be dropped
    task automatic test_spare_codes;
        for (int code = 5; code <= 7; code++)
        begin
            apply_settings(24'h2AAAAA, {21'h1FFFFF, 3'(code)}, 16'h8000, 1'b0);
            send_tick(1'b0);
        end
    endtask

    task automatic test_skewed_edges;
        // no rising part at all; phase zero starts the fall at +full scale
        apply_settings(24'h800000, WAVE_SKEWED, 16'h0000, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        // break point near the end: land past it, then exactly on it
        apply_settings(24'hFFFF80, WAVE_SKEWED, 16'hFFFF, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        // tiny break point with a unit step
        apply_settings(24'h000001, WAVE_SKEWED, 16'h0001, 1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // A write to index 3 must leave every register as it was
    task automatic test_ignored_index;
        drain();
        write_reg(CFG_UNUSED_IDX, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        send_tick(1'b0);
    endtask

    task automatic test_random_run;
        logic [23:0] inc;
        logic [23:0] wave_word;
        logic [15:0] skew;
        logic [2:0]  code;
        for (int ph = 0; ph < RUN_PHASES; ph++)
        begin
            case ($urandom_range(0, 5))
                0:       inc = 24'($urandom());
                1:       inc = 24'($urandom_range(1, 4095));
                2:       inc = 24'(24'hFFFFFF - $urandom_range(0, 4095));
                3:       inc = 24'h1 << $urandom_range(0, 23);
                4:       inc = 24'($urandom_range(24'h010000, 24'h200000));
                default: inc = 24'h000000;
            endcase
            // every shape early, then mostly random with the skewed shape favored
            if (ph < 5)
                code = 3'(ph);
            else if ($urandom_range(0, 2) == 0)
                code = WAVE_SKEWED;
            else
                code = 3'($urandom_range(0, 7));
            wave_word = {($urandom_range(0, 1) == 0) ? 21'h0 : 21'($urandom()), code};
            case ($urandom_range(0, 5))
                0:       skew = 16'h0000;
                1:       skew = 16'hFFFF;
                2:       skew = 16'h0001;
                3:       skew = 16'h8000;
                default: skew = 16'($urandom());
            endcase
            apply_settings(inc, wave_word, skew, $urandom_range(0, 3) == 0);
            // closing phases run at full rate on both sides
            idle_on = (ph < RUN_PHASES - 2);
            for (int n = 0; n < RUN_TICKS; n++)
                send_tick($urandom_range(0, 15) == 0);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_basic_shapes();
        test_spare_codes();
        test_skewed_edges();
        test_ignored_index();
        idle_on = 1'b1;
        test_random_run();

        drain();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d ticks (%0d with restart) over %0d register settings",
                 tick_count, restart_count, setting_count);
        $display("Ticks per waveform code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 wave_hits[0], wave_hits[1], wave_hits[2], wave_hits[3],
                 wave_hits[4], wave_hits[5], wave_hits[6], wave_hits[7]);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mwlfo_pkg.sv
rtl/core/mwlfo_div.sv
rtl/core/mwlfo_dp.sv
rtl/core/mwlfo_ctrl.sv
rtl/core/multi_wave_lfo.sv
tb/tb.sv
